### sv/mse_pkg.sv
// Package: shared constants, codes and word types for the multi-stack engine.
package mse_pkg;

    localparam int MAX_STACKS = 8;
    localparam int MAX_DEPTH  = 16;

    localparam int STK_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int ADDR_W = (MAX_STACKS * MAX_DEPTH > 1) ? $clog2(MAX_STACKS * MAX_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [31:0] NO_VALUE = 32'h8000_0000;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2
    } t_mse_req_code;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADNUM = 2'd3
    } t_mse_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STACKS = 1'b0,
        REG_DEPTH  = 1'b1
    } t_mse_reg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         stack_number;
        logic signed [31:0] push_data;
    } t_mse_req;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
        logic               now_empty;
        logic               now_full;
    } t_mse_rsp;

    // Decoded operation handed from the fill control to the datapath.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        t_mse_status       status;
        logic              now_empty;
        logic              now_full;
    } t_mse_op;

endpackage

### sv/mse_fill_ctl.sv
// Fill control: config registers, per-stack fill counts and request decode.
module mse_fill_ctl import mse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_mse_req              i_req,
    output t_mse_op               o_op
);

    logic [3:0]       r_stacks;
    logic [4:0]       r_depth;
    logic [CNT_W-1:0] r_fill [MAX_STACKS];

    logic             num_ok;
    logic [STK_W-1:0] sidx;
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] slot;
    logic [31:0]      depth_sat;

    always_comb begin
        depth_sat = (32'(r_depth) > MAX_DEPTH) ? MAX_DEPTH : 32'(r_depth);
        depth     = CNT_W'(depth_sat);
        num_ok    = (i_req.stack_number != 4'd0) && (i_req.stack_number <= r_stacks)
                    && (32'(i_req.stack_number) <= MAX_STACKS);
        sidx      = STK_W'(i_req.stack_number - 4'd1);
        cnt       = r_fill[sidx];
        n_cnt     = cnt;
        slot      = cnt;
        o_op      = '0;
        o_op.status = ST_OK;
        priority if (!num_ok) begin
            o_op.status = ST_BADNUM;
        end else if (i_req.req_type == REQ_PUSH) begin
            if (cnt >= depth) begin
                o_op.status = ST_FULL;
            end else begin
                o_op.wr_en = 1'b1;
                n_cnt      = cnt + CNT_W'(1);
            end
        end else if (cnt == '0) begin
            o_op.status = ST_EMPTY;
        end else begin
            // pop and peek both read the top entry; code 3 acts as peek
            o_op.rd_en = 1'b1;
            slot       = cnt - CNT_W'(1);
            if (i_req.req_type == REQ_POP) begin
                n_cnt = slot;
            end
        end
        o_op.addr = ADDR_W'(32'(sidx) * MAX_DEPTH + 32'(slot));
        if (num_ok) begin
            o_op.now_empty = (n_cnt == '0);
            o_op.now_full  = (n_cnt >= depth);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks <= 4'd1;
            r_depth  <= 5'd10;
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_mse_reg'(i_cfg_index))
                    REG_STACKS: r_stacks <= i_cfg_data[3:0];
                    REG_DEPTH:  r_depth  <= i_cfg_data[4:0];
                    default:    ;
                endcase
            end
            if (i_accept && num_ok) begin
                r_fill[sidx] <= n_cnt;
            end
        end
    end

endmodule

### sv/mse_entry_ram.sv
// Entry RAM: shared value store, one access per cycle, registered read data.
module mse_entry_ram import mse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [31:0]       i_wr_data,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [MAX_STACKS * MAX_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/multi_stack_engine_unit.sv
// Top level: multi-stack engine, LIFO stacks sharing one entry RAM.
//
//   channel   | direction | handshake              | word
//   ----------+-----------+------------------------+-------------------------------
//   in        | in        | i_in_valid / o_in_stall | t_mse_req (type, stack, data)
//   out       | out       | o_out_valid / i_out_stall | t_mse_rsp (data, status, flags)
//   cfg       | in        | i_cfg_valid / o_cfg_ready | register index + data
//
// A request word is decoded, updates its fill count and accesses the RAM on
// the accept edge; the registered RAM data then lands in the output register.
// With the single RAM port the engine takes no new request until then.
// A finished word may sit in the output register under i_out_stall while the
// next request is decoded; the engine then holds in its read stage.
// Reset (synchronous, active low) empties every stack and loads the
// config defaults; RAM contents are not cleared. While reset is held the
// input stalls and config is not ready; otherwise config is always ready.
module multi_stack_engine_unit import mse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_mse_req              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_mse_rsp              o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mse_op     op;
    logic        accept;
    logic        finish;
    logic [31:0] ram_rd_data;

    // read stage: one request in flight between decode and output
    logic        r_busy;
    logic        r_use_ram;
    t_mse_status r_status;
    logic        r_empty;
    logic        r_full;

    logic        r_out_valid;
    t_mse_rsp    r_out_word;

    assign accept      = i_in_valid && !r_busy && i_rst_n;
    assign finish      = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_busy || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    mse_fill_ctl u_fill_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_req       (i_in_word),
        .o_op        (op)
    );

    mse_entry_ram u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && op.wr_en),
        .i_rd_en   (accept && op.rd_en),
        .i_addr    (op.addr),
        .i_wr_data (i_in_word.push_data),
        .o_rd_data (ram_rd_data)
    );

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_use_ram <= op.rd_en;
            r_status  <= op.status;
            r_empty   <= op.now_empty;
            r_full    <= op.now_full;
        end
        if (finish) begin
            r_out_word.read_data <= r_use_ram ? ram_rd_data : NO_VALUE;
            r_out_word.status    <= r_status;
            r_out_word.now_empty <= r_empty;
            r_out_word.now_full  <= r_full;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### bench/multi_stack_engine_unit_test.sv
// Testbench for the multi-stack engine: directed probes, then random traffic per config.
`timescale 1ns / 100ps

module multi_stack_engine_unit_test;
    import mse_pkg::*;

    // Request code 3 has no name in the package; the engine decodes it as a peek.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE      = 4;    // pipe drain plus margin
    localparam int unsigned TAIL        = 20;
    localparam int unsigned MAX_GAP     = 18;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned SEGS        = 3;
    localparam int unsigned SEG_LEN     = 40;
    localparam int unsigned SHOW_LIMIT  = 10;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_mse_req              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_mse_rsp              o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    multi_stack_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stack predictor: own copy of fill levels, entries and registers
    // ------------------------------------------------------------------
    logic [3:0]  cfg_stacks = 4'd1;
    logic [4:0]  cfg_depth  = 5'd10;
    logic [4:0]  fill_lvl [MAX_STACKS];
    logic [31:0] entry_mem [MAX_STACKS * MAX_DEPTH];

    initial begin
        foreach (fill_lvl[k]) fill_lvl[k] = '0;
        foreach (entry_mem[k]) entry_mem[k] = '0;
    end

    function automatic int unsigned live_stacks();
        return (cfg_stacks > MAX_STACKS) ? MAX_STACKS : 32'(cfg_stacks);
    endfunction

    // Applies one request to the shadow stacks and returns the word it yields.
    function automatic t_mse_rsp stack_model_op(input t_mse_req w);
        t_mse_rsp    r;
        int unsigned lim;
        int unsigned sel;
        int unsigned lvl;
        lim = (cfg_depth > MAX_DEPTH) ? MAX_DEPTH : 32'(cfg_depth);
        r.read_data = NO_VALUE;
        r.status    = ST_OK;
        r.now_empty = 1'b0;
        r.now_full  = 1'b0;
        if (w.stack_number == 0 || w.stack_number > live_stacks()) begin
            r.status = ST_BADNUM;
            return r;
        end
        sel = w.stack_number - 1;
        lvl = 32'(fill_lvl[sel]);
        if (w.req_type == REQ_PUSH) begin
            if (lvl >= lim) begin
                r.status = ST_FULL;
            end else begin
                entry_mem[sel * MAX_DEPTH + lvl] = w.push_data;
                lvl++;
            end
        end else if (lvl == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // pop, peek, and the spare code (read as peek)
            r.read_data = entry_mem[sel * MAX_DEPTH + lvl - 1];
            if (w.req_type == REQ_POP) lvl--;
        end
        fill_lvl[sel] = 5'(lvl);
        r.now_empty = (lvl == 0);
        r.now_full  = (lvl >= lim);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: in-order compare against words still owed
    // ------------------------------------------------------------------
    t_mse_rsp    rsp_due_q [$];
    int unsigned bad_cnt   = 0;
    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        t_mse_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_due_q.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= SHOW_LIMIT)
                    $display("unexpected word: data %h status %0d empty %0b full %0b",
                             o_out_word.read_data, o_out_word.status,
                             o_out_word.now_empty, o_out_word.now_full);
            end else begin
                want = rsp_due_q.pop_front();
                if (o_out_word.read_data !== want.read_data ||
                    o_out_word.status    !== want.status    ||
                    o_out_word.now_empty !== want.now_empty ||
                    o_out_word.now_full  !== want.now_full) begin
                    bad_cnt++;
                    if (bad_cnt <= SHOW_LIMIT)
                        $display("mismatch: want data %h st %0d e %0b f %0b, got data %h st %0d e %0b f %0b",
                                 want.read_data, want.status, want.now_empty, want.now_full,
                                 o_out_word.read_data, o_out_word.status,
                                 o_out_word.now_empty, o_out_word.now_full);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output-side back-pressure: a fresh stall run drawn per accepted word
    // ------------------------------------------------------------------
    bit          sink_quiet = 1'b0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_draw  = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
            stall_left  <= stall_draw;
            i_out_stall <= (stall_draw != 0);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Called on a clock step with nothing yet scheduled on i_in_valid.
    task automatic issue_req(input t_mse_req w, input int unsigned gap,
                             input bit use_given, input t_mse_rsp given);
        t_mse_rsp calc;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        calc = stack_model_op(w);
        rsp_due_q.push_back(use_given ? given : calc);
    endtask

    // Stop sending and let every owed word drain, then let the pipe settle.
    task automatic drain_engine();
        i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_mse_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_STACKS) cfg_stacks = val[3:0];
        else                   cfg_depth  = val;
    endtask

    // ------------------------------------------------------------------
    // Directed probes, run at the reset config (one stack, depth ten)
    // ------------------------------------------------------------------
    typedef struct {
        t_mse_req w;
        bit       given;
        t_mse_rsp rsp;
    } t_probe;

    t_probe probe_q [$];

    function automatic void add_probe(input logic [1:0] op, input logic [3:0] num,
                                      input logic [31:0] data, input bit given = 1'b0,
                                      input logic [31:0] rd = NO_VALUE,
                                      input t_mse_status st = ST_OK,
                                      input bit emp = 1'b0, input bit ful = 1'b0);
        t_probe p;
        p.w.req_type      = op;
        p.w.stack_number  = num;
        p.w.push_data     = data;
        p.given           = given;
        p.rsp.read_data   = rd;
        p.rsp.status      = st;
        p.rsp.now_empty   = emp;
        p.rsp.now_full    = ful;
        probe_q.push_back(p);
    endfunction

    // Random config sweep; 31 on the stack register masks to 15 and saturates.
    logic [CFG_DATA_W-1:0] phase_stacks [NUM_PHASES] = '{5'd8, 5'd0, 5'd31, 5'd3, 5'd8,
                                                         5'd2, 5'd1, 5'd5, 5'd7};
    logic [CFG_DATA_W-1:0] phase_depth  [NUM_PHASES] = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd0,
                                                         5'd4, 5'd16, 5'd10, 5'd3};

    initial begin
        t_mse_req    w;
        int unsigned live;
        int unsigned focus;
        int unsigned push_pct;
        int unsigned pick;
        bit          src_quiet;

        // empty stack reads, all three read codes
        add_probe(REQ_POP,   4'd1, 32'h0, 1'b1, NO_VALUE, ST_EMPTY, 1'b1, 1'b0);
        add_probe(REQ_PEEK,  4'd1, 32'h0, 1'b1, NO_VALUE, ST_EMPTY, 1'b1, 1'b0);
        add_probe(REQ_SPARE, 4'd1, 32'h0, 1'b1, NO_VALUE, ST_EMPTY, 1'b1, 1'b0);
        // stack numbers zero, one past the count, and all ones
        add_probe(REQ_PUSH,  4'd0,  32'h0000_1234, 1'b1, NO_VALUE, ST_BADNUM);
        add_probe(REQ_POP,   4'd2,  32'h0,         1'b1, NO_VALUE, ST_BADNUM);
        add_probe(REQ_PEEK,  4'hF,  32'hFFFF_FFFF, 1'b1, NO_VALUE, ST_BADNUM);
        // fill stack one to its depth of ten with the data extremes
        add_probe(REQ_PUSH,  4'd1, 32'h7FFF_FFFF, 1'b1, NO_VALUE, ST_OK);
        add_probe(REQ_PEEK,  4'd1, 32'h0,         1'b1, 32'h7FFF_FFFF, ST_OK);
        add_probe(REQ_PUSH,  4'd1, 32'h8000_0000);
        add_probe(REQ_PUSH,  4'd1, 32'h0000_0000);
        add_probe(REQ_PUSH,  4'd1, 32'hFFFF_FFFF);
        add_probe(REQ_PUSH,  4'd1, 32'h0000_0001);
        add_probe(REQ_PUSH,  4'd1, 32'h5555_5555);
        add_probe(REQ_PUSH,  4'd1, 32'hAAAA_AAAA);
        add_probe(REQ_PUSH,  4'd1, 32'h0000_FFFF);
        add_probe(REQ_PUSH,  4'd1, 32'hFFFF_0000);
        add_probe(REQ_PUSH,  4'd1, 32'h1357_9BDF, 1'b1, NO_VALUE, ST_OK, 1'b0, 1'b1);
        // push onto a full stack is refused and stores nothing
        add_probe(REQ_PUSH,  4'd1, 32'h2468_ACE0, 1'b1, NO_VALUE, ST_FULL, 1'b0, 1'b1);
        add_probe(REQ_SPARE, 4'd1, 32'h0);
        add_probe(REQ_POP,   4'd1, 32'h0);
        add_probe(REQ_POP,   4'd1, 32'h0);
        add_probe(REQ_PEEK,  4'd1, 32'h0);
        add_probe(REQ_POP,   4'd1, 32'h0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_q[k])
            issue_req(probe_q[k].w, $urandom_range(0, 3), probe_q[k].given, probe_q[k].rsp);

        // Random part: per config phase, segments that lean on one stack and
        // swing between filling and draining so full and empty both get hit.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_engine();
            write_reg(REG_STACKS, phase_stacks[ph]);
            write_reg(REG_DEPTH,  phase_depth[ph]);
            i_cfg_valid <= 1'b0;
            live = live_stacks();

            for (int seg = 0; seg < SEGS; seg++) begin
                // hold off until the engine is empty once per phase
                if (seg == 1) drain_engine();
                focus      = (live == 0) ? 1 : $urandom_range(1, live);
                push_pct   = (seg % 2 == 0) ? 75 : 25;
                src_quiet  = ($urandom_range(0, 3) == 0);
                sink_quiet = ($urandom_range(0, 3) == 0);

                for (int k = 0; k < SEG_LEN; k++) begin
                    pick = $urandom_range(0, 99);
                    if (live == 0)
                        w.stack_number = 4'($urandom_range(0, 15));
                    else if (pick < 70)
                        w.stack_number = 4'(focus);
                    else if (pick < 90)
                        w.stack_number = 4'($urandom_range(1, live));
                    else
                        w.stack_number = $urandom_range(0, 1) ? 4'd0
                                         : 4'($urandom_range(live + 1, 15));

                    pick = $urandom_range(0, 99);
                    if (pick < push_pct)
                        w.req_type = REQ_PUSH;
                    else if (pick < push_pct + (100 - push_pct) / 2)
                        w.req_type = REQ_POP;
                    else
                        w.req_type = ($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_PEEK;
                    w.push_data = $urandom;

                    issue_req(w, src_quiet ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (bad_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/mse_pkg.sv
sv/mse_fill_ctl.sv
sv/mse_entry_ram.sv
sv/multi_stack_engine_unit.sv
bench/multi_stack_engine_unit_test.sv
